FILE: rtl/core/swm_pkg.sv
package swm_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 7;

    // register map: word index = paddr[2]
    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(4);

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_STEP
    } t_cell_op;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic [CFG_W-1:0]         age;
    } t_entry;

    typedef struct packed {
        t_cell_op                 op;
        logic                     evict;
        logic                     start;
        logic signed [DATA_W-1:0] sample;
    } t_cell_ctl;

endpackage

FILE: rtl/core/sliding_window_maximum_unit.sv
// Sliding window maximum over a stream of signed 32-bit samples. Each beat on
// the input channel carries one sample and a start flag; the start flag opens
// a new sequence and empties the window. Once window_size samples of the
// current sequence have arrived, every input beat yields one output beat, the
// largest sample of the last window_size samples, in the next cycle. The
// window size (register 0, byte address 0, 1..min(WINDOW_MAX, 127); 0 acts
// as 1, larger values saturate) may be changed only while the block is idle.
// Throughput is one sample per cycle; a result beat held by output stall
// holds off the next sample until it is taken. After the window is shrunk,
// the front of the candidate queue may hold several stale entries; they are
// dropped one per cycle while the next sample is held off, the last one
// along with that sample. The queue is a row of WINDOW_MAX cells, each with
// its own 32-bit compare; the front cell holds the current maximum.
module sliding_window_maximum_unit #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [swm_pkg::DATA_W-1:0] i_sample,
    input  logic                              i_start_req,
    // result output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [swm_pkg::DATA_W-1:0] o_window_max,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // largest window the 7-bit register can ask for, capped by the cell count
    localparam int K_MAX_INT = (WINDOW_MAX < (1 << swm_pkg::CFG_W) - 1) ?
                               WINDOW_MAX : (1 << swm_pkg::CFG_W) - 1;
    localparam logic [swm_pkg::CFG_W-1:0] K_MAX = swm_pkg::CFG_W'(K_MAX_INT);

    localparam swm_pkg::t_entry EMPTY = '{valid: 1'b0, value: '0, age: '0};

    logic [swm_pkg::CFG_W-1:0]         r_window_size;
    logic [swm_pkg::CFG_W-1:0]         r_filled;
    logic [swm_pkg::CFG_W-1:0]         n_filled;
    logic                              r_out_valid;
    logic signed [swm_pkg::DATA_W-1:0] r_out_data;
    logic [swm_pkg::CFG_W-1:0]         w_k;
    logic [swm_pkg::CFG_W-1:0]         w_fill_base;
    logic                              w_accept;
    logic                              w_evict;
    logic                              w_drain;
    logic                              w_emit;
    logic signed [swm_pkg::DATA_W-1:0] w_front;
    swm_pkg::t_entry                   w_view0;
    swm_pkg::t_cell_ctl                w_ctl;
    swm_pkg::t_entry                   w_entry [WINDOW_MAX];
    logic                              w_keep  [WINDOW_MAX];

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[2] == swm_pkg::REG_WINDOW_SIZE) begin
            prdata = {{(32 - swm_pkg::CFG_W){1'b0}}, r_window_size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::WINDOW_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == swm_pkg::REG_WINDOW_SIZE) begin
            r_window_size <= pwdata[swm_pkg::CFG_W-1:0];
        end
    end

    // effective window length
    always_comb begin
        w_k = r_window_size;
        if (w_k == '0) begin
            w_k = swm_pkg::CFG_W'(1);
        end else if (w_k > K_MAX) begin
            w_k = K_MAX;
        end
    end

    // ---------------- queue control ----------------
    // front entry out of the window: drop it along with this sample's update
    assign w_evict = w_entry[0].valid && (w_entry[0].age >= w_k);
    // two stale entries at the front (only after a shrink): drop one alone
    assign w_drain = w_evict && w_entry[1].valid && (w_entry[1].age >= w_k);

    assign o_in_stall = w_drain || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_ctl.op     = swm_pkg::CELL_HOLD;
        w_ctl.evict  = w_evict;
        w_ctl.start  = i_start_req;
        w_ctl.sample = i_sample;
        if (w_drain) begin
            w_ctl.op = swm_pkg::CELL_SHIFT;
        end else if (w_accept) begin
            w_ctl.op = swm_pkg::CELL_STEP;
        end
    end

    // ---------------- cell row ----------------
    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        swm_pkg::t_entry w_right;
        logic            w_left_keep;

        if (gi == WINDOW_MAX - 1) begin : g_last
            assign w_right = EMPTY;
        end else begin : g_mid
            assign w_right = w_entry[gi+1];
        end

        if (gi == 0) begin : g_first
            assign w_left_keep = 1'b1;
        end else begin : g_rest
            assign w_left_keep = w_keep[gi-1];
        end

        swm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_right     (w_right),
            .i_left_keep (w_left_keep),
            .o_keep      (w_keep[gi]),
            .o_entry     (w_entry[gi])
        );
    end

    // new front after this sample: surviving old front, else the sample itself
    assign w_view0 = w_evict ? w_entry[1] : w_entry[0];
    assign w_front = w_keep[0] ? w_view0.value : i_sample;

    // ---------------- fill count and result ----------------
    assign w_fill_base = i_start_req ? '0 : r_filled;
    assign n_filled    = (w_fill_base == K_MAX) ? K_MAX
                                                : w_fill_base + swm_pkg::CFG_W'(1);
    assign w_emit      = n_filled >= w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_filled <= n_filled;
            end
            if (w_accept && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept && w_emit) begin
            r_out_data <= w_front;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_data;

`ifndef ASSERT_OFF
    // the two front entries of the queue are in non-increasing order
    a_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_entry[0].valid && w_entry[1].valid) |-> (w_entry[0].value >= w_entry[1].value))
        else $error("candidate queue not monotonic");

    // the queue is never empty after a sample is taken in
    a_front_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_entry[0].valid)
        else $error("queue front empty after a sample");

    // a start leaves exactly one entry
    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_start_req) |=> !w_entry[1].valid)
        else $error("start did not clear the queue");

    // a result beat appears only after an accepted sample
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_accept))
        else $error("result without a sample");
`endif

endmodule

FILE: rtl/core/swm_cell.sv
module swm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swm_pkg::t_cell_ctl i_ctl,
    input  swm_pkg::t_entry    i_right,
    input  logic               i_left_keep,
    output logic               o_keep,
    output swm_pkg::t_entry    o_entry
);

    logic                              r_valid;
    logic signed [swm_pkg::DATA_W-1:0] r_value;
    logic [swm_pkg::CFG_W-1:0]         r_age;
    logic                              n_valid;
    logic signed [swm_pkg::DATA_W-1:0] n_value;
    logic [swm_pkg::CFG_W-1:0]         n_age;
    swm_pkg::t_entry                   w_own;
    swm_pkg::t_entry                   w_view;

    assign w_own  = '{valid: r_valid, value: r_value, age: r_age};
    // queue view after the front entry has left
    assign w_view = i_ctl.evict ? i_right : w_own;
    assign o_keep = w_view.valid && (w_view.value >= i_ctl.sample) && !i_ctl.start;
    assign o_entry = w_own;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_age   = r_age;
        case (i_ctl.op)
            swm_pkg::CELL_SHIFT: begin
                n_valid = i_right.valid;
                n_value = i_right.value;
                n_age   = i_right.age;
            end
            swm_pkg::CELL_STEP: begin
                if (o_keep) begin
                    n_valid = 1'b1;
                    n_value = w_view.value;
                    n_age   = (&w_view.age) ? w_view.age
                                            : w_view.age + swm_pkg::CFG_W'(1);
                end else if (i_left_keep) begin
                    // first free slot takes the new sample
                    n_valid = 1'b1;
                    n_value = i_ctl.sample;
                    n_age   = swm_pkg::CFG_W'(1);
                end else begin
                    n_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_age   <= n_age;
    end

endmodule

FILE: bench/tb_sliding_window_maximum_unit.sv
`timescale 1ns / 100ps

module tb_sliding_window_maximum_unit;

    localparam int WIN_MAX   = 64;
    localparam int POS_MOD   = 2 * WIN_MAX;   // stream positions wrap here
    localparam int ITEM_GOAL = 550;
    localparam int LIMIT_NS  = 5_000_000;     // far above the slowest run
    localparam int EXP_DEPTH = 16;

    localparam logic signed [31:0] S_MIN = 32'h8000_0000;
    localparam logic signed [31:0] S_MAX = 32'h7fff_ffff;

    // shapes of random sample streams
    typedef enum int {
        PAT_ANY,
        PAT_NARROW,     // tiny range, lots of equal samples
        PAT_RISE,       // every new sample tends to flush the queue
        PAT_FALL,       // queue grows to the window length
        PAT_CORNER      // two's complement extremes
    } t_pattern;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              i_in_valid   = 1'b0;
    logic                              o_in_stall;
    logic signed [swm_pkg::DATA_W-1:0] i_sample     = '0;
    logic                              i_start_req  = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_stall  = 1'b0;
    logic signed [swm_pkg::DATA_W-1:0] o_window_max;
    logic                              psel         = 1'b0;
    logic                              penable      = 1'b0;
    logic                              pwrite       = 1'b0;
    logic [2:0]                        paddr        = '0;
    logic [31:0]                       pwdata       = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    sliding_window_maximum_unit #(
        .WINDOW_MAX (WIN_MAX)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_start_req  (i_start_req),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_window_max (o_window_max),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: monotonic deque of (value, position), front = max
    // ------------------------------------------------------------------
    logic [swm_pkg::CFG_W-1:0] win_reg = swm_pkg::WINDOW_RESET;
    logic signed [31:0]        kept_val [WIN_MAX];
    int                        kept_pos [WIN_MAX];
    int                        dq_head  = 0;
    int                        dq_count = 0;
    int                        stream_pos = 0;
    int                        fill_count = 0;

    logic signed [31:0] exp_fifo [EXP_DEPTH];   // window maxima still to arrive
    int                 exp_wr     = 0;
    int                 exp_rd     = 0;
    logic signed [31:0] want_max;
    int                 beats_sent = 0;
    int                 fail_count = 0;
    bit                 in_gaps    = 1'b1;  // sender idles between beats
    bit                 out_gaps   = 1'b1;  // receiver stalls after beats

    // 0 acts as 1, anything above the deque depth saturates
    function automatic int eff_window(input logic [swm_pkg::CFG_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > WIN_MAX)
            return WIN_MAX;
        return int'(w);
    endfunction

    // Takes one sample into the predicted deque; returns 1 when the window
    // is full and hands back the expected maximum.
    function automatic bit slide_window(input logic signed [31:0] smp, input bit st,
                                        output logic signed [31:0] mx);
        int k;
        int age;
        int b;
        k = eff_window(win_reg);
        if (st) begin
            dq_head    = 0;
            dq_count   = 0;
            stream_pos = 0;
            fill_count = 0;
        end
        // age out the front by position, not by value
        while (dq_count > 0) begin
            age = (stream_pos + POS_MOD - kept_pos[dq_head]) % POS_MOD;
            if (age < k)
                break;
            dq_head  = (dq_head + 1) % WIN_MAX;
            dq_count = dq_count - 1;
        end
        // pop strictly smaller tail entries; equal ones stay
        while (dq_count > 0) begin
            b = (dq_head + dq_count - 1) % WIN_MAX;
            if (kept_val[b] >= smp)
                break;
            dq_count = dq_count - 1;
        end
        if (dq_count < WIN_MAX) begin
            b = (dq_head + dq_count) % WIN_MAX;
            kept_val[b] = smp;
            kept_pos[b] = stream_pos;
            dq_count    = dq_count + 1;
        end
        stream_pos = (stream_pos + 1) % POS_MOD;
        if (fill_count < WIN_MAX)
            fill_count = fill_count + 1;
        mx = kept_val[dq_head];
        return fill_count >= k;
    endfunction

    function automatic logic signed [31:0] next_sample(input t_pattern pat,
                                                       input logic signed [31:0] prev);
        logic signed [31:0] v;
        case (pat)
            PAT_NARROW: v = $urandom_range(0, 6) - 3;
            PAT_RISE:   v = prev + $urandom_range(0, 999);
            PAT_FALL:   v = prev - $urandom_range(0, 999);
            PAT_CORNER: begin
                case ($urandom_range(0, 5))
                    0:       v = S_MIN;
                    1:       v = S_MAX;
                    2:       v = 0;
                    3:       v = -1;
                    4:       v = S_MIN + 1;
                    default: v = S_MAX - 1;
                endcase
            end
            default:    v = $urandom();
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("sliding_window_maximum_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: one beat on the sample channel. Handshakes are sampled at the
    // falling edge, where everything launched at the rising edge is stable,
    // so the beat is known to complete at the following rising edge. Valid
    // stays high between back-to-back beats (no drop and re-raise in one step).
    // ------------------------------------------------------------------
    task automatic send_sample(input logic signed [31:0] smp, input bit st);
        int                 gap;
        bit                 took;
        logic signed [31:0] mx;
        gap = in_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample    <= smp;
        i_start_req <= st;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end
        if (slide_window(smp, st, mx)) begin
            exp_fifo[exp_wr % EXP_DEPTH] = mx;
            exp_wr++;
        end
        beats_sent++;
    endtask

    // Quiesce: all maxima delivered, then room for the stale-entry drain that
    // can follow a shrink.
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (WIN_MAX + 4) @(posedge i_clk);
    endtask

    // APB write of the window register; upper data bits are junk and must be
    // ignored by the 7-bit register.
    task automatic set_window(input logic [swm_pkg::CFG_W-1:0] size);
        logic [31:0] junk;
        bit          done;
        junk = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {swm_pkg::REG_WINDOW_SIZE, 2'b00};
        pwdata  <= {junk[31:swm_pkg::CFG_W], size};
        @(posedge i_clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        win_reg = size;
    endtask

    // ------------------------------------------------------------------
    // Receiver: after each result beat, stall a random number of cycles
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        bit got;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            got = 1'b0;
            while (!got) begin
                @(negedge i_clk);
                got = o_out_valid;
                @(posedge i_clk);
            end
            hold = out_gaps ? $urandom_range(0, 9) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Checker: every result beat against the oldest predicted maximum
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_wr == exp_rd) begin
                $error("window_max: no result expected, got %0d", o_window_max);
                fail_count++;
            end else begin
                want_max = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_window_max !== want_max) begin
                    $error("window_max: expected %0d, got %0d", want_max, o_window_max);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset window of 4, extremes, equal samples, restarts, window 0 and 2
    task automatic test_directed_edges();
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        send_sample(S_MAX, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(0, 1'b0);          // first full window
        send_sample(S_MIN, 1'b0);      // old max ages out by position
        repeat (4) send_sample(7, 1'b0);
        send_sample(1, 1'b1);          // restart, never fills
        send_sample(2, 1'b0);
        send_sample(3, 1'b1);          // restart again
        repeat (3) send_sample(3, 1'b0);
        settle_idle();
        set_window('0);                // zero acts as one
        send_sample(S_MIN, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(-5, 1'b0);
        settle_idle();
        set_window(7'd2);
        send_sample(5, 1'b1);
        send_sample(5, 1'b0);
        send_sample(-3, 1'b0);
        send_sample(S_MAX, 1'b0);
    endtask

    // Largest window with a full deque, then shrink and grow mid-sequence;
    // the long unbroken sequence also wraps the position counter.
    task automatic test_window_resize();
        logic signed [31:0] v;
        int                 i;
        settle_idle();
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        set_window(swm_pkg::CFG_W'(WIN_MAX));
        v = S_MAX;
        for (i = 0; i < 70; i++) begin
            v = next_sample(PAT_FALL, v);
            send_sample(v, i == 0);
        end
        settle_idle();
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        set_window(7'd5);              // many stale entries at the front
        for (i = 0; i < 10; i++) begin
            v = next_sample(PAT_FALL, v);
            send_sample(v, 1'b0);
        end
        settle_idle();
        set_window(7'd40);             // growth, fill count already saturated
        for (i = 0; i < 50; i++) begin
            v = next_sample(PAT_ANY, v);
            send_sample(v, 1'b0);
        end
        settle_idle();
        set_window('0);
        for (i = 0; i < 8; i++)
            send_sample(next_sample(PAT_CORNER, v), 1'b0);
        settle_idle();
        in_gaps = 1'b0;
        set_window(7'h7f);             // saturates to the deque depth
        for (i = 0; i < 70; i++) begin
            v = next_sample(PAT_ANY, v);
            send_sample(v, i == 0);
        end
    endtask

    // Random phases: mostly a fresh window, random idling, a few sequences each
    task automatic test_random_streams();
        int                        k;
        int                        len;
        int                        nseq;
        int                        s;
        int                        i;
        bit                        st;
        t_pattern                  pat;
        logic signed [31:0]        v;
        logic [swm_pkg::CFG_W-1:0] w;
        v = 0;
        while (beats_sent < ITEM_GOAL) begin
            settle_idle();
            in_gaps  = ($urandom_range(0, 3) != 0);
            out_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 19)) inside
                    0:       w = '0;
                    1:       w = 7'h7f;
                    2:       w = swm_pkg::CFG_W'($urandom_range(WIN_MAX + 1, 126));
                    3:       w = swm_pkg::CFG_W'(WIN_MAX);
                    [4:7]:   w = swm_pkg::CFG_W'($urandom_range(9, 40));
                    default: w = swm_pkg::CFG_W'($urandom_range(1, 8));
                endcase
                set_window(w);
            end
            k    = eff_window(win_reg);
            nseq = $urandom_range(1, 3);
            for (s = 0; s < nseq && beats_sent < ITEM_GOAL; s++) begin
                pat = t_pattern'($urandom_range(0, 4));
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(1, k);          // may never fill
                else
                    len = k + $urandom_range(0, 2 * k + 8);
                // first sequence of a phase sometimes carries on across the
                // window change
                st = !(s == 0 && $urandom_range(0, 3) == 0);
                for (i = 0; i < len && beats_sent < ITEM_GOAL; i++) begin
                    v = next_sample(pat, v);
                    send_sample(v, (i == 0 && st) || $urandom_range(0, 63) == 0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_window_resize();
        test_random_streams();
        settle_idle();
        if (fail_count == 0) begin
            $display("sliding_window_maximum_unit verification clean");
        end else begin
            $display("sliding_window_maximum_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: sliding_window_maximum_unit.f
rtl/core/swm_pkg.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_maximum_unit.sv
bench/tb_sliding_window_maximum_unit.sv
